>>> hw/rtl/cagr_pkg.sv
package cagr_pkg;

	localparam int COORD_BITS = 5;
	localparam int DIM_BITS   = 6;
	localparam int TURN_DEPTH = 64;
	localparam int TURN_BITS  = 6;

	localparam logic REG_GRID_WIDTH  = 1'b0;
	localparam logic REG_GRID_HEIGHT = 1'b1;

	localparam logic [1:0] KIND_EQUAL     = 2'd0;
	localparam logic [1:0] KIND_PATTERN   = 2'd1;
	localparam logic [1:0] KIND_BACKTRACE = 2'd2;

	typedef logic [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		coord_t     sx;
		coord_t     sy;
		coord_t     dx;
		coord_t     dy;
		logic [1:0] kind;
	} job_t;

endpackage

>>> hw/rtl/cagr_front.sv
module cagr_front #(
	parameter int MAX_COLUMNS = 32,
	parameter int MAX_ROWS    = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic                              cfg_index,
	input  logic [cagr_pkg::DIM_BITS-1:0]     cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  cagr_pkg::coord_t                  src_x,
	input  cagr_pkg::coord_t                  src_y,
	input  cagr_pkg::coord_t                  dst_x,
	input  cagr_pkg::coord_t                  dst_y,
	input  logic                              box_clear,
	input  logic                              q_full,
	input  logic                              clearing,
	output logic                              push,
	output cagr_pkg::job_t                    push_job
);

	logic [cagr_pkg::DIM_BITS-1:0] grid_width_q;
	logic [cagr_pkg::DIM_BITS-1:0] grid_height_q;
	logic [8:0] gw;
	logic [8:0] gh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= 6'd32;
			grid_height_q <= 6'd32;
		end else if (cfg_we) begin
			case (cfg_index)
				cagr_pkg::REG_GRID_WIDTH:  grid_width_q  <= cfg_data;
				cagr_pkg::REG_GRID_HEIGHT: grid_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	function automatic logic [8:0] clamp_dim(input logic [5:0] v, input logic [8:0] maxv);
		logic [8:0] r;
		r = {3'b000, v};
		if (r == 9'd0) r = 9'd1;
		else if (r > maxv) r = maxv;
		return r;
	endfunction

	function automatic cagr_pkg::coord_t clamp_coord(input cagr_pkg::coord_t v,
			input logic [8:0] lim);
		logic [8:0] m;
		m = lim - 9'd1;
		return ({4'b0000, v} >= lim) ? m[4:0] : v;
	endfunction

	always_comb begin
		gw = clamp_dim(grid_width_q, 9'(MAX_COLUMNS));
		gh = clamp_dim(grid_height_q, 9'(MAX_ROWS));
		push_job.sx = clamp_coord(src_x, gw);
		push_job.sy = clamp_coord(src_y, gh);
		push_job.dx = clamp_coord(dst_x, gw);
		push_job.dy = clamp_coord(dst_y, gh);
		if (push_job.sx == push_job.dx && push_job.sy == push_job.dy)
			push_job.kind = cagr_pkg::KIND_EQUAL;
		else if (box_clear)
			push_job.kind = cagr_pkg::KIND_PATTERN;
		else
			push_job.kind = cagr_pkg::KIND_BACKTRACE;
	end

	assign in_stall = q_full | clearing;
	assign push     = in_valid & ~in_stall;

endmodule

>>> hw/rtl/cagr_queue.sv
module cagr_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  cagr_pkg::job_t push_job,
	input  logic           pop,
	output cagr_pkg::job_t pop_job,
	output logic           full,
	output logic           empty
);

	cagr_pkg::job_t entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop) count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_job;
	end

	assign pop_job = entry_q[rd_ptr_q];
	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);

endmodule

>>> hw/rtl/cagr_back.sv
module cagr_back #(
	parameter int MAX_COLUMNS = 32,
	parameter int MAX_ROWS    = 32,
	parameter int WEIGHT_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  cagr_pkg::job_t   pop_job,
	output logic             pop,
	output logic             clearing,
	output logic             out_valid,
	input  logic             out_stall,
	output cagr_pkg::coord_t point_x,
	output cagr_pkg::coord_t point_y,
	output logic             last
);

	localparam int CELLS = MAX_COLUMNS * MAX_ROWS;
	localparam int AW    = $clog2(CELLS);

	localparam logic [3:0] ST_CLR     = 4'd0;
	localparam logic [3:0] ST_IDLE    = 4'd1;
	localparam logic [3:0] ST_PH_RD   = 4'd2;
	localparam logic [3:0] ST_PH_UPD  = 4'd3;
	localparam logic [3:0] ST_PV_RD   = 4'd4;
	localparam logic [3:0] ST_PV_UPD  = 4'd5;
	localparam logic [3:0] ST_BT_RD   = 4'd6;
	localparam logic [3:0] ST_BT_UPD  = 4'd7;
	localparam logic [3:0] ST_EM_SRC  = 4'd8;
	localparam logic [3:0] ST_EM_MID  = 4'd9;
	localparam logic [3:0] ST_EM_TRD  = 4'd10;
	localparam logic [3:0] ST_EM_TOUT = 4'd11;
	localparam logic [3:0] ST_EM_DST  = 4'd12;

	logic [WEIGHT_BITS-1:0] h_mem [CELLS];
	logic [WEIGHT_BITS-1:0] v_mem [CELLS];
	logic [2*cagr_pkg::COORD_BITS-1:0] turn_mem [cagr_pkg::TURN_DEPTH];

	logic [3:0]             state_q;
	logic [AW-1:0]          clr_q;
	cagr_pkg::coord_t       sx_q, sy_q, dx_q, dy_q;
	logic [1:0]             kind_q;
	cagr_pkg::coord_t       cx_q, cy_q, kx_q, ky_q;
	cagr_pkg::coord_t       pos_q, end_q;
	logic [cagr_pkg::TURN_BITS-1:0] turns_q;
	logic [WEIGHT_BITS-1:0] h_rd_q, v_rd_q;
	logic [2*cagr_pkg::COORD_BITS-1:0] t_rd_q;
	logic                   out_valid_q;
	cagr_pkg::coord_t       point_x_q, point_y_q;
	logic                   last_q;

	logic                   h_re, v_re, h_we, v_we;
	logic [AW-1:0]          h_raddr, v_raddr;
	logic [WEIGHT_BITS-1:0] h_wdata, v_wdata;
	logic                   has_h, has_v, pick_v;
	cagr_pkg::coord_t       nx, ny;
	logic                   out_free;
	logic                   load;
	cagr_pkg::coord_t       load_x, load_y;
	logic                   load_last;

	function automatic logic [AW-1:0] cell_addr(input cagr_pkg::coord_t x,
			input cagr_pkg::coord_t y);
		return AW'(32'(y) * 32'(MAX_COLUMNS) + 32'(x));
	endfunction

	function automatic logic [WEIGHT_BITS-1:0] sat_inc(input logic [WEIGHT_BITS-1:0] w);
		return (&w) ? w : w + 1'b1;
	endfunction

	assign out_free = ~out_valid_q | ~out_stall;
	assign has_h    = (cx_q != sx_q);
	assign has_v    = (cy_q != sy_q);
	assign pick_v   = has_v & (~has_h | (v_rd_q < h_rd_q));

	always_comb begin
		nx = cx_q;
		ny = cy_q;
		if (pick_v) ny = (cy_q > sy_q) ? cy_q - 5'd1 : cy_q + 5'd1;
		else nx = (cx_q > sx_q) ? cx_q - 5'd1 : cx_q + 5'd1;
	end

	always_comb begin
		h_re    = 1'b0;
		v_re    = 1'b0;
		h_we    = 1'b0;
		v_we    = 1'b0;
		h_raddr = cell_addr(pos_q, sy_q);
		v_raddr = cell_addr(dx_q, pos_q);
		h_wdata = sat_inc(h_rd_q);
		v_wdata = sat_inc(v_rd_q);
		case (state_q)
			ST_CLR: begin
				h_we    = 1'b1;
				v_we    = 1'b1;
				h_raddr = clr_q;
				v_raddr = clr_q;
				h_wdata = WEIGHT_BITS'(1);
				v_wdata = WEIGHT_BITS'(1);
			end
			ST_PH_RD:  h_re = (pos_q != end_q);
			ST_PH_UPD: h_we = 1'b1;
			ST_PV_RD:  v_re = (pos_q != end_q);
			ST_PV_UPD: v_we = 1'b1;
			ST_BT_RD, ST_BT_UPD: begin
				h_raddr = (cx_q > sx_q) ? cell_addr(cx_q - 5'd1, cy_q) : cell_addr(cx_q, cy_q);
				v_raddr = (cy_q > sy_q) ? cell_addr(cx_q, cy_q - 5'd1) : cell_addr(cx_q, cy_q);
				h_re    = (state_q == ST_BT_RD);
				v_re    = (state_q == ST_BT_RD);
				h_we    = (state_q == ST_BT_UPD) & ~pick_v;
				v_we    = (state_q == ST_BT_UPD) & pick_v;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (h_we) h_mem[h_raddr] <= h_wdata;
		if (h_re) h_rd_q <= h_mem[h_raddr];
		if (v_we) v_mem[v_raddr] <= v_wdata;
		if (v_re) v_rd_q <= v_mem[v_raddr];
		if (state_q == ST_BT_UPD && kx_q != nx && ky_q != ny)
			turn_mem[turns_q] <= {cy_q, cx_q};
		if (state_q == ST_EM_TRD)
			t_rd_q <= turn_mem[turns_q - 6'd1];
	end

	always_comb begin
		load      = 1'b0;
		load_x    = dx_q;
		load_y    = dy_q;
		load_last = 1'b0;
		case (state_q)
			ST_EM_SRC: begin
				load   = out_free;
				load_x = sx_q;
				load_y = sy_q;
			end
			ST_EM_MID: begin
				load   = out_free;
				load_y = sy_q;
			end
			ST_EM_TOUT: begin
				load   = out_free;
				load_x = t_rd_q[4:0];
				load_y = t_rd_q[9:5];
			end
			ST_EM_DST: begin
				load      = out_free;
				load_last = 1'b1;
			end
			default: ;
		endcase
	end

	assign pop = (state_q == ST_IDLE) & ~q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) out_valid_q <= 1'b1;
			else if (~out_stall) out_valid_q <= 1'b0;
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(CELLS - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (!q_empty) begin
						if (pop_job.kind == cagr_pkg::KIND_EQUAL) state_q <= ST_EM_DST;
						else if (pop_job.kind == cagr_pkg::KIND_PATTERN) state_q <= ST_PH_RD;
						else state_q <= ST_BT_RD;
					end
				end
				ST_PH_RD: state_q <= (pos_q == end_q) ? ST_PV_RD : ST_PH_UPD;
				ST_PH_UPD: state_q <= ST_PH_RD;
				ST_PV_RD: state_q <= (pos_q == end_q) ? ST_EM_SRC : ST_PV_UPD;
				ST_PV_UPD: state_q <= ST_PV_RD;
				ST_BT_RD: state_q <= (has_h | has_v) ? ST_BT_UPD : ST_EM_SRC;
				ST_BT_UPD: state_q <= ST_BT_RD;
				ST_EM_SRC: begin
					if (out_free) begin
						if (kind_q == cagr_pkg::KIND_PATTERN)
							state_q <= (sx_q != dx_q && sy_q != dy_q) ? ST_EM_MID : ST_EM_DST;
						else
							state_q <= (turns_q != '0) ? ST_EM_TRD : ST_EM_DST;
					end
				end
				ST_EM_MID: if (out_free) state_q <= ST_EM_DST;
				ST_EM_TRD: state_q <= ST_EM_TOUT;
				ST_EM_TOUT: begin
					if (out_free) state_q <= (turns_q == 6'd1) ? ST_EM_DST : ST_EM_TRD;
				end
				ST_EM_DST: if (out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			point_x_q <= load_x;
			point_y_q <= load_y;
			last_q    <= load_last;
		end
		case (state_q)
			ST_IDLE: begin
				sx_q    <= pop_job.sx;
				sy_q    <= pop_job.sy;
				dx_q    <= pop_job.dx;
				dy_q    <= pop_job.dy;
				kind_q  <= pop_job.kind;
				cx_q    <= pop_job.dx;
				cy_q    <= pop_job.dy;
				kx_q    <= pop_job.dx;
				ky_q    <= pop_job.dy;
				turns_q <= '0;
				pos_q   <= (pop_job.sx < pop_job.dx) ? pop_job.sx : pop_job.dx;
				end_q   <= (pop_job.sx < pop_job.dx) ? pop_job.dx : pop_job.sx;
			end
			ST_PH_RD: begin
				if (pos_q == end_q) begin
					pos_q <= (sy_q < dy_q) ? sy_q : dy_q;
					end_q <= (sy_q < dy_q) ? dy_q : sy_q;
				end
			end
			ST_PH_UPD, ST_PV_UPD: pos_q <= pos_q + 5'd1;
			ST_BT_UPD: begin
				if (kx_q != nx && ky_q != ny) begin
					turns_q <= turns_q + 6'd1;
					kx_q    <= cx_q;
					ky_q    <= cy_q;
				end
				cx_q <= nx;
				cy_q <= ny;
			end
			ST_EM_TOUT: if (out_free) turns_q <= turns_q - 6'd1;
			default: ;
		endcase
	end

	assign clearing  = (state_q == ST_CLR);
	assign out_valid = out_valid_q;
	assign point_x   = point_x_q;
	assign point_y   = point_y_q;
	assign last      = last_q;

endmodule

>>> hw/rtl/congestion_aware_grid_router_unit.sv
// Two-pin net router over a grid of weighted unit edges.
// Input channel (in_valid / in_stall): one net per item, src and dst pins
// plus box_clear. An item is taken when in_valid is high and in_stall low.
// Output channel (out_valid / out_stall): route points source to target,
// turn cells between them, last high on the target point.
// Configuration: cfg_we with cfg_index 0 (grid_width) or 1 (grid_height).
// After reset the edge weights are set to one by a clearing pass over all
// MAX_COLUMNS*MAX_ROWS cells (1024 by default); in_stall stays high
// during it. A two-entry queue lets a second net be taken while one routes.
// Pattern route: each edge weight on the path is read and then updated,
// then its points are sent; backtrace does one weight read and one weight
// write per move and reads each turn cell back from turn memory on output.
// One net is routed at a time. A stalled output holds its point and the
// router waits on it; the queue keeps accepting until full.
module congestion_aware_grid_router_unit #(
	parameter int MAX_COLUMNS = 32,
	parameter int MAX_ROWS    = 32,
	parameter int WEIGHT_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [cagr_pkg::DIM_BITS-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [4:0]                    src_x,
	input  logic [4:0]                    src_y,
	input  logic [4:0]                    dst_x,
	input  logic [4:0]                    dst_y,
	input  logic                          box_clear,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [4:0]                    point_x,
	output logic [4:0]                    point_y,
	output logic                          last
);

	logic           push, pop, q_full, q_empty, clearing;
	cagr_pkg::job_t push_job, pop_job;

	cagr_front #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_ROWS   (MAX_ROWS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.src_x    (src_x),
		.src_y    (src_y),
		.dst_x    (dst_x),
		.dst_y    (dst_y),
		.box_clear(box_clear),
		.q_full   (q_full),
		.clearing (clearing),
		.push     (push),
		.push_job (push_job)
	);

	cagr_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.pop     (pop),
		.pop_job (pop_job),
		.full    (q_full),
		.empty   (q_empty)
	);

	cagr_back #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_ROWS   (MAX_ROWS),
		.WEIGHT_BITS(WEIGHT_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.pop_job  (pop_job),
		.pop      (pop),
		.clearing (clearing),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.point_x  (point_x),
		.point_y  (point_y),
		.last     (last)
	);

endmodule

>>> tb/sv/route_checker.sv
module route_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [5:0] cfg_data,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [4:0] src_x,
	input  logic [4:0] src_y,
	input  logic [4:0] dst_x,
	input  logic [4:0] dst_y,
	input  logic       box_clear,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [4:0] point_x,
	input  logic [4:0] point_y,
	input  logic       last,
	output int         errors,
	output int         pending
);

	localparam int WMAX = 65535;

	typedef struct packed {
		cagr_pkg::coord_t x;
		cagr_pkg::coord_t y;
		logic             fin;
	} point_t;

	int     h_use [1024];
	int     v_use [1024];
	logic [5:0] width_reg, height_reg;
	point_t route_q [$];

	task automatic report(input string msg);
		$display("tb: mismatch: %s", msg);
		errors++;
	endtask

	function automatic int clamp_dim(input logic [5:0] v);
		if (v == 0) return 1;
		return (v > 32) ? 32 : int'(v);
	endfunction

	function automatic int clamp_coord(input logic [4:0] v, input int lim);
		return (int'(v) >= lim) ? lim - 1 : int'(v);
	endfunction

	function automatic void bump_h(input int x, input int y);
		if (h_use[y*32+x] < WMAX) h_use[y*32+x]++;
	endfunction

	function automatic void bump_v(input int x, input int y);
		if (v_use[y*32+x] < WMAX) v_use[y*32+x]++;
	endfunction

	function automatic void push(input int x, input int y, input logic f);
		point_t p;
		p.x = cagr_pkg::coord_t'(x);
		p.y = cagr_pkg::coord_t'(y);
		p.fin = f;
		route_q.insert(route_q.size(), p);
	endfunction

	function automatic void route_net(input logic [4:0] ax, input logic [4:0] ay,
			input logic [4:0] bx, input logic [4:0] by, input logic clear);
		int gw, gh, sx, sy, dx, dy, cx, cy, kx, ky, nx, ny, bw, sel, nturn;
		int turn_x [64];
		int turn_y [64];
		gw = clamp_dim(width_reg);
		gh = clamp_dim(height_reg);
		sx = clamp_coord(ax, gw);
		sy = clamp_coord(ay, gh);
		dx = clamp_coord(bx, gw);
		dy = clamp_coord(by, gh);
		nturn = 0;
		if (sx == dx && sy == dy) begin
			push(dx, dy, 1'b1);
			return;
		end
		if (clear) begin
			for (int x = (sx < dx ? sx : dx); x < (sx < dx ? dx : sx); x++)
				bump_h(x, sy);
			for (int y = (sy < dy ? sy : dy); y < (sy < dy ? dy : sy); y++)
				bump_v((sx == dx) ? sx : dx, y);
			push(sx, sy, 1'b0);
			if (sx != dx && sy != dy)
				push(dx, sy, 1'b0);
			push(dx, dy, 1'b1);
			return;
		end
		cx = dx; cy = dy; kx = dx; ky = dy;
		while (cx != sx || cy != sy) begin
			sel = -1; bw = 0; nx = cx; ny = cy;
			if (cx > sx) begin
				sel = 0; bw = h_use[cy*32+cx-1]; nx = cx - 1; ny = cy;
			end
			if (cx < sx && (sel < 0 || h_use[cy*32+cx] < bw)) begin
				sel = 1; bw = h_use[cy*32+cx]; nx = cx + 1; ny = cy;
			end
			if (cy > sy && (sel < 0 || v_use[(cy-1)*32+cx] < bw)) begin
				sel = 2; bw = v_use[(cy-1)*32+cx]; nx = cx; ny = cy - 1;
			end
			if (cy < sy && (sel < 0 || v_use[cy*32+cx] < bw)) begin
				sel = 3; bw = v_use[cy*32+cx]; nx = cx; ny = cy + 1;
			end
			case (sel)
				0: bump_h(cx - 1, cy);
				1: bump_h(cx, cy);
				2: bump_v(cx, cy - 1);
				default: bump_v(cx, cy);
			endcase
			if (kx != nx && ky != ny) begin
				if (nturn < 64) begin
					turn_x[nturn] = cx;
					turn_y[nturn] = cy;
					nturn++;
				end
				kx = cx; ky = cy;
			end
			cx = nx; cy = ny;
		end
		push(sx, sy, 1'b0);
		for (int i = nturn - 1; i >= 0; i--)
			push(turn_x[i], turn_y[i], 1'b0);
		push(dx, dy, 1'b1);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 1024; i++) begin
				h_use[i] = 1;
				v_use[i] = 1;
			end
			width_reg = 6'd32;
			height_reg = 6'd32;
			route_q.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == cagr_pkg::REG_GRID_WIDTH) width_reg = cfg_data;
				else height_reg = cfg_data;
			end
			if (out_valid && !out_stall) begin
				if (route_q.size() == 0) begin
					report($sformatf("unexpected point (%0d,%0d) last=%0b",
						point_x, point_y, last));
				end else begin
					point_t e;
					e = route_q.pop_front();
					if (point_x !== e.x)
						report($sformatf("point_x %0d, want %0d", point_x, e.x));
					if (point_y !== e.y)
						report($sformatf("point_y %0d, want %0d", point_y, e.y));
					if (last !== e.fin)
						report($sformatf("last %0b, want %0b", last, e.fin));
				end
			end
			if (in_valid && !in_stall)
				route_net(src_x, src_y, dst_x, dst_y, box_clear);
			pending = route_q.size();
		end
	end
endmodule

>>> tb/sv/tb.sv
module tb;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic       cfg_index = cagr_pkg::REG_GRID_WIDTH;
	logic [5:0] cfg_data = '0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [4:0] src_x = '0, src_y = '0, dst_x = '0, dst_y = '0;
	logic       box_clear = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [4:0] point_x, point_y;
	logic       last;
	int         errors, pending;
	int         idle_cycles = 0;
	bit         hold_mode = 0;
	int         hold_left = 0;

	always #5 clk = ~clk;

	congestion_aware_grid_router_unit dut (.*);

	route_checker chk (.*);

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (hold_mode) begin
			hold_mode <= 0;
			hold_left <= 400;
			out_stall <= 1'b1;
		end else begin
			case ($urandom_range(0, 3))
				0: out_stall <= ($urandom_range(0, 1) == 1);
				1: out_stall <= ($urandom_range(0, 9) < 7);
				default: out_stall <= 1'b0;
			endcase
		end
	end

	task automatic send(input int ax, input int ay, input int bx, input int by,
			input bit clear);
		in_valid <= 1'b1;
		src_x <= 5'(ax); src_y <= 5'(ay);
		dst_x <= 5'(bx); dst_y <= 5'(by);
		box_clear <= clear;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic pause(input int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic set_grid(input int w, input int h);
		cfg_we <= 1'b1;
		cfg_index <= cagr_pkg::REG_GRID_WIDTH;
		cfg_data <= 6'(w);
		@(posedge clk);
		cfg_index <= cagr_pkg::REG_GRID_HEIGHT;
		cfg_data <= 6'(h);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_net(input int w, input int h);
		int lim_w, lim_h;
		lim_w = (w > 31 || w == 0) ? 31 : w - 1;
		lim_h = (h > 31 || h == 0) ? 31 : h - 1;
		if ($urandom_range(0, 9) == 0)
			send($urandom_range(0, 31), $urandom_range(0, 31),
				$urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 1));
		else
			send($urandom_range(0, lim_w), $urandom_range(0, lim_h),
				$urandom_range(0, lim_w), $urandom_range(0, lim_h),
				$urandom_range(0, 1));
	endtask

	initial begin
		int w, h, burst;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(0, 0, 31, 31, 1'b1);
		send(31, 31, 0, 0, 1'b1);
		send(0, 0, 31, 31, 1'b0);
		send(31, 0, 0, 31, 1'b0);
		send(5, 5, 5, 5, 1'b0);
		send(7, 3, 7, 3, 1'b1);
		send(2, 9, 20, 9, 1'b1);
		send(4, 1, 4, 30, 1'b1);
		send(4, 1, 4, 30, 1'b0);
		send(10, 10, 12, 14, 1'b0);
		send(10, 10, 12, 14, 1'b0);
		send(12, 14, 10, 10, 1'b0);
		send(0, 31, 31, 0, 1'b0);
		drain();

		set_grid(0, 0);
		send(3, 9, 31, 17, 1'b0);
		send(0, 0, 0, 0, 1'b1);
		drain();
		set_grid(63, 40);
		send(31, 31, 0, 0, 1'b0);
		send(0, 31, 31, 31, 1'b1);
		drain();
		set_grid(6, 1);
		send(0, 0, 31, 31, 1'b0);
		send(31, 5, 1, 0, 1'b1);
		drain();
		set_grid(32, 32);

		hold_mode <= 1;
		for (int i = 0; i < 12; i++)
			random_net(32, 32);
		drain();

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin w = 32; h = 32; end
				1: begin w = 1; h = 32; end
				2: begin w = 8; h = 8; end
				3: begin w = 32; h = 2; end
				4: begin w = $urandom_range(1, 32); h = $urandom_range(1, 32); end
				default: begin w = 32; h = 32; end
			endcase
			set_grid(w, h);
			for (int n = 0; n < 68; ) begin
				burst = $urandom_range(1, 12);
				for (int k = 0; k < burst; k++) begin
					random_net(w, h);
					n++;
				end
				if ($urandom_range(0, 2) != 0)
					pause($urandom_range(1, 15));
			end
			drain();
		end

		if (errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end
endmodule

>>> congestion_aware_grid_router_unit.f
hw/rtl/cagr_pkg.sv
hw/rtl/cagr_front.sv
hw/rtl/cagr_queue.sv
hw/rtl/cagr_back.sv
hw/rtl/congestion_aware_grid_router_unit.sv
tb/sv/route_checker.sv
tb/sv/tb.sv
